[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the responder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TAR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("telecontrol responder check failed");

// Next-cycle implication, off while reset is asserted.
`define TAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("telecontrol responder check failed");

// Next-cycle implication that is also checked during reset.
`define TAR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("telecontrol responder reset check failed");

`endif

[rtl/tar_pkg.sv]
// Shared types and constants of the telecontrol APDU responder.
package tar_pkg;

    localparam int NUM_POINTS = 3;

    localparam logic [7:0] START_BYTE         = 8'h68;
    localparam logic [7:0] TYPE_INTERROGATION = 8'd100;
    localparam logic [7:0] TYPE_SINGLE_POINT  = 8'd1;
    localparam logic [7:0] CAUSE_ACT_CON      = 8'd7;
    localparam logic [7:0] CAUSE_ACT_TERM     = 8'd10;
    localparam logic [7:0] CAUSE_INTERROGATED = 8'd20;
    localparam logic [7:0] CMD_LEN            = 8'd14;
    localparam logic [7:0] U_LEN              = 8'd4;
    localparam logic [7:0] SQ_FLAG            = 8'h80;
    localparam logic [7:0] POINTS_LEN         = 8'(13 + NUM_POINTS);
    localparam logic [7:0] POINTS_QUAL        = 8'(8'h80 | NUM_POINTS);
    localparam logic [1:0] FMT_U              = 2'b11;

    // U format confirmation control bytes.
    localparam logic [7:0] U_STARTDT_CON = 8'h0B;
    localparam logic [7:0] U_STOPDT_CON  = 8'h23;
    localparam logic [7:0] U_TESTFR_CON  = 8'h83;
    localparam logic [7:0] U_BARE        = 8'h03;

    // Byte positions inside the reply frames.
    localparam int CMD_LAST_IDX    = 15;
    localparam int POINTS_DATA_IDX = 15;
    localparam int POINTS_LAST_IDX = 14 + NUM_POINTS;
    localparam int U_LAST_IDX      = 5;
    localparam int IDX_W           = $clog2(POINTS_LAST_IDX + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LEN,
        PH_BODY
    } t_parse_phase;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CMD_CON,
        BK_POINTS,
        BK_CMD_TERM,
        BK_U_REPLY
    } t_bk_state;

    // One reply job handed from the parser to the reply generator.
    typedef struct packed {
        logic        is_intr;
        logic [7:0]  u_ctrl;
        logic [14:0] rcv_count;
    } t_cmd;

endpackage

[rtl/tar_front.sv]
// Frame parser: finds frames in the byte stream and queues one reply job per answered frame.
module tar_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output tar_pkg::t_cmd     o_cmd
);

    tar_pkg::t_parse_phase r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_type, n_type;
    logic [14:0] r_rcv, n_rcv;

    logic        accept;
    logic [7:0]  pos_inc;
    logic [7:0]  ctrl_eff;
    logic [7:0]  type_eff;
    logic        frame_done;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign pos_inc = r_pos + 8'd1;
    assign ctrl_eff = (r_pos == 8'd0) ? i_byte : r_ctrl;
    assign type_eff = (r_pos == 8'd4) ? i_byte : r_type;
    assign frame_done = accept && (r_phase == tar_pkg::PH_BODY) && (pos_inc >= r_len);

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                tar_pkg::PH_WAIT: begin
                    n_phase = (i_byte == tar_pkg::START_BYTE) ? tar_pkg::PH_LEN
                                                               : tar_pkg::PH_WAIT;
                end
                tar_pkg::PH_LEN: begin
                    n_phase = (i_byte == 8'd0) ? tar_pkg::PH_WAIT : tar_pkg::PH_BODY;
                end
                tar_pkg::PH_BODY: begin
                    if (pos_inc >= r_len) begin
                        n_phase = tar_pkg::PH_WAIT;
                    end
                end
                default: begin
                    n_phase = tar_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // Field capture, receive count and reply job.
    always_comb begin
        n_len  = r_len;
        n_pos  = r_pos;
        n_ctrl = r_ctrl;
        n_type = r_type;
        n_rcv  = r_rcv;
        o_push = 1'b0;
        o_cmd  = '{is_intr: 1'b0, u_ctrl: tar_pkg::U_BARE, rcv_count: r_rcv};
        if (accept && r_phase == tar_pkg::PH_LEN) begin
            n_len  = i_byte;
            n_pos  = 8'd0;
            n_ctrl = 8'd0;
            n_type = 8'd0;
        end
        if (accept && r_phase == tar_pkg::PH_BODY) begin
            n_pos  = pos_inc;
            n_ctrl = ctrl_eff;
            n_type = type_eff;
        end
        if (frame_done) begin
            if (!ctrl_eff[0]) begin
                n_rcv = r_rcv + 15'd1;
                o_cmd.rcv_count = n_rcv;
                o_cmd.is_intr   = 1'b1;
                o_push = (type_eff == tar_pkg::TYPE_INTERROGATION);
            end else if (ctrl_eff[1:0] == tar_pkg::FMT_U) begin
                o_push = 1'b1;
                if (ctrl_eff[2]) begin
                    o_cmd.u_ctrl = tar_pkg::U_STARTDT_CON;
                end else if (ctrl_eff[4]) begin
                    o_cmd.u_ctrl = tar_pkg::U_STOPDT_CON;
                end else if (ctrl_eff[6]) begin
                    o_cmd.u_ctrl = tar_pkg::U_TESTFR_CON;
                end else begin
                    o_cmd.u_ctrl = tar_pkg::U_BARE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tar_pkg::PH_WAIT;
            r_len   <= 8'd0;
            r_pos   <= 8'd0;
            r_ctrl  <= 8'd0;
            r_type  <= 8'd0;
            r_rcv   <= 15'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_ctrl  <= n_ctrl;
            r_type  <= n_type;
            r_rcv   <= n_rcv;
        end
    end

endmodule

[rtl/tar_queue.sv]
// Small job queue between the parser and the reply generator.
module tar_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tar_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output tar_pkg::t_cmd o_cmd
);

    tar_pkg::t_cmd r_mem [tar_pkg::QUEUE_DEPTH];
    logic [tar_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [tar_pkg::QPTR_W:0]   r_count;

    assign o_full  = (r_count == (tar_pkg::QPTR_W + 1)'(tar_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + tar_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + tar_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (tar_pkg::QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (tar_pkg::QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/tar_back.sv]
// Reply generator: turns queued jobs into reply frames, one byte per cycle while the output is ready.
module tar_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tar_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_frame_end,
    output logic          o_last
);

    tar_pkg::t_bk_state r_state, n_state;
    tar_pkg::t_cmd      r_cmd;
    logic [tar_pkg::IDX_W-1:0] r_idx;
    logic [14:0]        r_send;
    logic               r_point;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_end;
    logic               r_out_last;

    logic               out_free;
    logic               adv;
    logic               frame_last;
    logic               job_last;
    logic [7:0]         byte_val;
    logic [7:0]         cause;

    assign out_free = !r_out_valid || i_ready;

    // Output-side decisions and the byte of the current position.
    always_comb begin
        adv        = (r_state != tar_pkg::BK_IDLE) && out_free;
        frame_last = 1'b0;
        job_last   = 1'b0;
        byte_val   = 8'd0;
        cause      = (r_state == tar_pkg::BK_CMD_CON) ? tar_pkg::CAUSE_ACT_CON
                                                       : tar_pkg::CAUSE_ACT_TERM;
        case (r_state)
            tar_pkg::BK_CMD_CON, tar_pkg::BK_CMD_TERM: begin
                frame_last = (r_idx == tar_pkg::IDX_W'(tar_pkg::CMD_LAST_IDX));
                job_last   = frame_last && (r_state == tar_pkg::BK_CMD_TERM);
                case (r_idx)
                    tar_pkg::IDX_W'(0):  byte_val = tar_pkg::START_BYTE;
                    tar_pkg::IDX_W'(1):  byte_val = tar_pkg::CMD_LEN;
                    tar_pkg::IDX_W'(2):  byte_val = {r_send[6:0], 1'b0};
                    tar_pkg::IDX_W'(3):  byte_val = r_send[14:7];
                    tar_pkg::IDX_W'(4):  byte_val = {r_cmd.rcv_count[6:0], 1'b0};
                    tar_pkg::IDX_W'(5):  byte_val = r_cmd.rcv_count[14:7];
                    tar_pkg::IDX_W'(6):  byte_val = tar_pkg::TYPE_INTERROGATION;
                    tar_pkg::IDX_W'(7):  byte_val = 8'd1;
                    tar_pkg::IDX_W'(8):  byte_val = cause;
                    tar_pkg::IDX_W'(10): byte_val = 8'd1;
                    tar_pkg::IDX_W'(15): byte_val = tar_pkg::CAUSE_INTERROGATED;
                    default:             byte_val = 8'd0;
                endcase
            end
            tar_pkg::BK_POINTS: begin
                frame_last = (r_idx == tar_pkg::IDX_W'(tar_pkg::POINTS_LAST_IDX));
                case (r_idx)
                    tar_pkg::IDX_W'(0):  byte_val = tar_pkg::START_BYTE;
                    tar_pkg::IDX_W'(1):  byte_val = tar_pkg::POINTS_LEN;
                    tar_pkg::IDX_W'(2):  byte_val = {r_send[6:0], 1'b0};
                    tar_pkg::IDX_W'(3):  byte_val = r_send[14:7];
                    tar_pkg::IDX_W'(4):  byte_val = {r_cmd.rcv_count[6:0], 1'b0};
                    tar_pkg::IDX_W'(5):  byte_val = r_cmd.rcv_count[14:7];
                    tar_pkg::IDX_W'(6):  byte_val = tar_pkg::TYPE_SINGLE_POINT;
                    tar_pkg::IDX_W'(7):  byte_val = tar_pkg::POINTS_QUAL;
                    tar_pkg::IDX_W'(8):  byte_val = tar_pkg::CAUSE_INTERROGATED;
                    tar_pkg::IDX_W'(10): byte_val = 8'd1;
                    tar_pkg::IDX_W'(12): byte_val = 8'd1;
                    default: begin
                        byte_val = (r_idx >= tar_pkg::IDX_W'(tar_pkg::POINTS_DATA_IDX))
                                   ? {7'd0, r_point} : 8'd0;
                    end
                endcase
            end
            tar_pkg::BK_U_REPLY: begin
                frame_last = (r_idx == tar_pkg::IDX_W'(tar_pkg::U_LAST_IDX));
                job_last   = frame_last;
                case (r_idx)
                    tar_pkg::IDX_W'(0): byte_val = tar_pkg::START_BYTE;
                    tar_pkg::IDX_W'(1): byte_val = tar_pkg::U_LEN;
                    tar_pkg::IDX_W'(2): byte_val = r_cmd.u_ctrl;
                    default:            byte_val = 8'd0;
                endcase
            end
            default: begin
                adv = 1'b0;
            end
        endcase
        // A new job is taken when idle or right as the previous one emits its last byte.
        o_q_pop = i_q_valid && ((r_state == tar_pkg::BK_IDLE) || (adv && job_last));
    end

    // Next sequencer state.
    always_comb begin
        n_state = r_state;
        if (o_q_pop) begin
            n_state = i_q_cmd.is_intr ? tar_pkg::BK_CMD_CON : tar_pkg::BK_U_REPLY;
        end else if (adv && frame_last) begin
            case (r_state)
                tar_pkg::BK_CMD_CON: n_state = tar_pkg::BK_POINTS;
                tar_pkg::BK_POINTS:  n_state = tar_pkg::BK_CMD_TERM;
                default:             n_state = tar_pkg::BK_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (adv) begin
            r_out_byte <= byte_val;
            r_out_end  <= frame_last;
            r_out_last <= job_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tar_pkg::BK_IDLE;
            r_idx       <= '0;
            r_send      <= 15'd0;
            r_point     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_idx <= frame_last ? '0 : r_idx + tar_pkg::IDX_W'(1);
                if (frame_last && r_state != tar_pkg::BK_U_REPLY) begin
                    r_send <= r_send + 15'd1;
                end
                if (frame_last && r_state == tar_pkg::BK_POINTS) begin
                    r_point <= 1'b1;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_byte      = r_out_byte;
    assign o_frame_end = r_out_end;
    assign o_last      = r_out_last;

endmodule

[rtl/telecontrol_apdu_responder.sv]
// Top level of the telecontrol APDU responder: parser, job queue and reply generator.
//
// The responder takes one received word (byte) per cycle on the rx channel and
// answers telecontrol frames on the tx channel, one word per cycle while tx is
// ready. A parser finds frames that start with 0x68, takes the length byte and
// skips the body, keeping the first control byte and the type byte. When a
// frame ends it is classified: an S frame is silent, a U frame gets a six-word
// confirmation, and an I frame advances the 15-bit receive count and, when its
// type is the interrogation command, queues three reply frames (activation
// confirmation, single-point values, activation termination). Finished frames
// are handed as jobs through a four-entry queue to the reply generator, so the
// rx side keeps taking one word per cycle while replies drain; rx stalls only
// when four jobs are waiting. The reply generator holds the send count and the
// point value and emits one word per cycle while tx is ready, with no gap
// between frames or jobs. An interrogation job is 50 words and a U job 6, so
// sustained throughput is set by how fast the tx side drains those words. On
// tx, o_frame_end marks the final word of every reply frame and o_last the
// final word of all replies caused by one received frame.
module telecontrol_apdu_responder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_tx_valid,
    input  logic       i_tx_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_frame_end,
    output logic       o_last
);

    logic          push;
    tar_pkg::t_cmd push_cmd;
    logic          q_full;
    logic          q_valid;
    tar_pkg::t_cmd q_cmd;
    logic          q_pop;

    // Front: frame parser and receive counter.
    tar_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_rx_valid),
        .i_byte   (i_rx_byte),
        .i_q_full (q_full),
        .o_ready  (o_rx_ready),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // Queue of reply jobs between parser and generator.
    tar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: reply frame sequencer with its output register.
    tar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_ready     (i_tx_ready),
        .o_valid     (o_tx_valid),
        .o_byte      (o_tx_byte),
        .o_frame_end (o_frame_end),
        .o_last      (o_last)
    );

endmodule

[rtl/tar_checker.sv]
// Port-level checks of the responder and their binding to the top level.
`include "assert_macros.svh"

module tar_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_tx_valid,
    input logic       i_tx_ready,
    input logic [7:0] o_tx_byte,
    input logic       o_frame_end,
    input logic       o_last
);

    `TAR_ASSERT_NEXT(a_tx_hold, i_clk, i_rst_n, o_tx_valid && !i_tx_ready, o_tx_valid)
    `TAR_ASSERT_NEXT(a_tx_byte, i_clk, i_rst_n, o_tx_valid && !i_tx_ready, $stable(o_tx_byte))
    `TAR_ASSERT_NEXT(a_tx_last, i_clk, i_rst_n, o_tx_valid && !i_tx_ready, $stable(o_last))
    `TAR_ASSERT_SAME(a_last_ends_frame, i_clk, i_rst_n, o_tx_valid && o_last, o_frame_end)
    `TAR_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_tx_valid)

endmodule

bind telecontrol_apdu_responder tar_checker u_tar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_tx_valid  (o_tx_valid),
    .i_tx_ready  (i_tx_ready),
    .o_tx_byte   (o_tx_byte),
    .o_frame_end (o_frame_end),
    .o_last      (o_last)
);
